>>> design/eur_pkg.sv
// ----------------------------------------------------------------------------
// eur_pkg
// Shared types, codes and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eur_pkg;

    localparam int TRIG_LOW_TICKS     = 4;
    localparam int TRIG_HIGH_TICKS    = 10;
    localparam int PING_TIMEOUT_TICKS = 6000;
    localparam int COUNT_WIDTH        = 16;

    localparam int US_PER_CM      = 58;
    localparam int MAX_CM_WIDTH   = 10;
    localparam int UNIT_WIDTH     = 2;
    localparam int LIMIT_WIDTH    = 16;
    localparam int DIST_WIDTH     = 16;
    localparam int STATUS_WIDTH   = 2;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 10;

    localparam logic [MAX_CM_WIDTH-1:0] MAX_CM_RESET = MAX_CM_WIDTH'(500);
    localparam logic [UNIT_WIDTH-1:0]   UNIT_RESET   = UNIT_WIDTH'(2);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_DIST = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNIT     = CFG_IDX_WIDTH'(1);

    localparam logic [UNIT_WIDTH-1:0] UNIT_US = UNIT_WIDTH'(0);
    localparam logic [UNIT_WIDTH-1:0] UNIT_CM = UNIT_WIDTH'(1);

    localparam logic [STATUS_WIDTH-1:0] ST_OK        = STATUS_WIDTH'(0);
    localparam logic [STATUS_WIDTH-1:0] ST_ECHO_HIGH = STATUS_WIDTH'(1);
    localparam logic [STATUS_WIDTH-1:0] ST_NO_ECHO   = STATUS_WIDTH'(2);
    localparam logic [STATUS_WIDTH-1:0] ST_TOO_LONG  = STATUS_WIDTH'(3);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_TLOW  = 5'b00010,
        PH_THIGH = 5'b00100,
        PH_WAIT  = 5'b01000,
        PH_MEAS  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [DIST_WIDTH-1:0]   distance;
        logic [STATUS_WIDTH-1:0] status;
        logic                    done_res;
        logic                    busy_res;
        logic                    trigger_level;
    } t_result;

endpackage

`default_nettype wire

>>> design/eur_cfg.sv
// ----------------------------------------------------------------------------
// eur_cfg
// Configuration registers: echo time limit and result unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eur_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [eur_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [eur_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output logic      [eur_pkg::LIMIT_WIDTH-1:0]     o_limit,
    output logic      [eur_pkg::UNIT_WIDTH-1:0]      o_unit
);
    import eur_pkg::*;

    logic [LIMIT_WIDTH-1:0] r_limit;
    logic [LIMIT_WIDTH-1:0] n_limit;
    logic [UNIT_WIDTH-1:0]  r_unit;

    // The limit is kept in microseconds so the per-tick compare needs no multiply.
    assign n_limit = LIMIT_WIDTH'(i_cfg_data[MAX_CM_WIDTH-1:0]) * LIMIT_WIDTH'(US_PER_CM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_WIDTH'(MAX_CM_RESET) * LIMIT_WIDTH'(US_PER_CM);
            r_unit  <= UNIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_DIST: r_limit <= n_limit;
                CFG_UNIT:     r_unit  <= i_cfg_data[UNIT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_limit     = r_limit;
    assign o_unit      = r_unit;

endmodule

`default_nettype wire

>>> design/eur_conv.sv
// ----------------------------------------------------------------------------
// eur_conv
// Converts an echo time in microseconds to the selected unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eur_conv (
    input  wire logic [eur_pkg::COUNT_WIDTH-1:0] i_us,
    input  wire logic [eur_pkg::UNIT_WIDTH-1:0]  i_unit,
    output logic      [eur_pkg::DIST_WIDTH-1:0]  o_value
);
    import eur_pkg::*;

    // Centimeters are us/58 and millimeters are floor(us*5/29), both done as
    // a multiply by a scaled reciprocal that is exact over the counter range.
    localparam int CM_SHIFT = 22;
    localparam int CM_MULW  = 17;
    localparam int MM_SHIFT = 24;
    localparam int MM_MULW  = 22;

    localparam logic [CM_MULW-1:0] CM_MULT = CM_MULW'(72316);
    localparam logic [MM_MULW-1:0] MM_MULT = MM_MULW'(2892625);

    logic [COUNT_WIDTH+CM_MULW-1:0] cm_prod;
    logic [COUNT_WIDTH+MM_MULW-1:0] mm_prod;
    logic [DIST_WIDTH-1:0]          cm_val;
    logic [DIST_WIDTH-1:0]          mm_val;

    assign cm_prod = (COUNT_WIDTH+CM_MULW)'(i_us) * (COUNT_WIDTH+CM_MULW)'(CM_MULT);
    assign mm_prod = (COUNT_WIDTH+MM_MULW)'(i_us) * (COUNT_WIDTH+MM_MULW)'(MM_MULT);
    assign cm_val  = DIST_WIDTH'(cm_prod >> CM_SHIFT);
    assign mm_val  = DIST_WIDTH'(mm_prod >> MM_SHIFT);

    always_comb begin
        case (i_unit)
            UNIT_US: o_value = DIST_WIDTH'(i_us);
            UNIT_CM: o_value = cm_val;
            default: o_value = mm_val;
        endcase
    end

endmodule

`default_nettype wire

>>> design/eur_seq.sv
// ----------------------------------------------------------------------------
// eur_seq
// Measurement sequencer: trigger pulse, echo wait and echo timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eur_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_step,
    input  wire logic                              i_command,
    input  wire logic                              i_echo,
    input  wire logic [eur_pkg::LIMIT_WIDTH-1:0]   i_limit,
    input  wire logic [eur_pkg::DIST_WIDTH-1:0]    i_conv_value,
    output logic      [eur_pkg::COUNT_WIDTH-1:0]   o_count,
    output eur_pkg::t_result                       o_result
);
    import eur_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] bumped;
    t_result                res;

    assign bumped = (r_count == CNT_MAX) ? CNT_MAX : r_count + CNT_ONE;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        res     = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_command) begin
                    n_phase = PH_TLOW;
                    n_count = CNT_ONE;
                end
            end
            PH_TLOW: begin
                if (32'(r_count) >= 32'(TRIG_LOW_TICKS)) begin
                    n_phase           = PH_THIGH;
                    n_count           = CNT_ONE;
                    res.trigger_level = 1'b1;
                end else begin
                    n_count = bumped;
                end
            end
            PH_THIGH: begin
                if (32'(r_count) >= 32'(TRIG_HIGH_TICKS)) begin
                    n_count = '0;
                    if (i_echo) begin
                        res.done_res = 1'b1;
                        res.status   = ST_ECHO_HIGH;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end else begin
                    n_count           = bumped;
                    res.trigger_level = 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_count = '0;
                    if (i_limit == '0) begin
                        res.done_res = 1'b1;
                        res.status   = ST_TOO_LONG;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_phase = PH_MEAS;
                    end
                end else if (32'(bumped) >= 32'(PING_TIMEOUT_TICKS) || bumped == CNT_MAX) begin
                    res.done_res = 1'b1;
                    res.status   = ST_NO_ECHO;
                    n_phase      = PH_IDLE;
                    n_count      = '0;
                end else begin
                    n_count = bumped;
                end
            end
            PH_MEAS: begin
                if (i_echo) begin
                    if (32'(bumped) >= 32'(i_limit) || bumped == CNT_MAX) begin
                        res.done_res = 1'b1;
                        res.status   = ST_TOO_LONG;
                        n_phase      = PH_IDLE;
                        n_count      = '0;
                    end else begin
                        n_count = bumped;
                    end
                end else begin
                    res.done_res = 1'b1;
                    res.status   = ST_OK;
                    res.distance = i_conv_value;
                    n_phase      = PH_IDLE;
                    n_count      = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
        res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_count  = r_count;
    assign o_result = res;

endmodule

`default_nettype wire

>>> design/ultrasonic_echo_ranger_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Ultrasonic echo ranging controller, one input word per microsecond tick.
// ----------------------------------------------------------------------------
// Every input word is one microsecond tick and produces exactly one output
// word. The block takes one word per clock cycle when the output side keeps
// up. Each accepted word is loaded into the input register and is then moved
// through the sequencer into the result register, which presents it on the
// output. A stalled output holds both registers and the input side waits
// with them. A start word while idle drives the trigger low for 4 ticks,
// high for 10, then times the echo; the result is reported in microseconds,
// centimeters or millimeters. The user must write configuration only while
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [0] echo_level
    input  wire logic                                s_axis_tuser,  // [0] command
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] trigger_level, [1] busy_res, [2] done_res, [4:3] status, [20:5] distance
    output logic      [23:0]                         m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [eur_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [eur_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);
    import eur_pkg::*;

    logic                   r_in_valid;
    logic                   r_in_command;
    logic                   r_in_echo;
    logic                   r_out_valid;
    t_result                r_out;
    logic                   step;
    logic [LIMIT_WIDTH-1:0] limit;
    logic [UNIT_WIDTH-1:0]  unit;
    logic [COUNT_WIDTH-1:0] count;
    logic [DIST_WIDTH-1:0]  conv_value;
    t_result                result;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    eur_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limit     (limit),
        .o_unit      (unit)
    );

    eur_conv u_conv (
        .i_us    (count),
        .i_unit  (unit),
        .o_value (conv_value)
    );

    eur_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_command    (r_in_command),
        .i_echo       (r_in_echo),
        .i_limit      (limit),
        .i_conv_value (conv_value),
        .o_count      (count),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_command <= s_axis_tuser;
            r_in_echo    <= s_axis_tdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

`default_nettype wire
